FILE: rtl/core/hme_pkg.sv
// Package for the Hubbard matrix element block: sizes, codes, item and command types.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package hme_pkg;

    localparam int MAX_SITES   = 16;
    localparam int MAX_HOPS    = 32;
    localparam int COEFF_WIDTH = 24;

    localparam int OP_W       = 2;
    localparam int MASK_W     = 16;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int INDEX_W    = 5;
    localparam int SITE_SEL_W = 4;
    localparam int FIELD_W    = 24;
    localparam int RESULT_W   = 32;

    localparam int SITE_CNT_W  = 5;
    localparam int HOP_CNT_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    localparam int SITE_LIM_W  = $clog2(MAX_SITES + 1);
    localparam int HOP_LIM_W   = $clog2(MAX_HOPS + 1);
    localparam int SITE_ADDR_W = $clog2(MAX_SITES);
    localparam int HOP_ADDR_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int STEP_W      = (HOP_ADDR_W > SITE_ADDR_W) ? HOP_ADDR_W : SITE_ADDR_W;
    localparam int ENTRY_W     = 2 * SITE_SEL_W + COEFF_WIDTH;

    localparam int ACC_BITS = COEFF_WIDTH + $clog2(2 * MAX_HOPS + 3 * MAX_SITES) + 1;
    localparam int ACC_W    = (ACC_BITS > RESULT_W + 1) ? ACC_BITS : RESULT_W + 1;

    localparam logic [OP_W-1:0] OP_EVAL       = 2'd0;
    localparam logic [OP_W-1:0] OP_HOP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SITE_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_COUNT  = 1'd1;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_ZERO  = 2'd0;
    localparam mode_t MODE_WRITE = 2'd1;
    localparam mode_t MODE_DIAG  = 2'd2;
    localparam mode_t MODE_HOP   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [MASK_W-1:0]         left_up;
        logic [MASK_W-1:0]         left_down;
        logic [MASK_W-1:0]         right_up;
        logic [MASK_W-1:0]         right_down;
        logic [INDEX_W-1:0]        entry_index;
        logic [SITE_SEL_W-1:0]     from_site;
        logic [SITE_SEL_W-1:0]     to_site;
        logic signed [FIELD_W-1:0] coeff_main;
        logic signed [FIELD_W-1:0] chem_up;
        logic signed [FIELD_W-1:0] chem_down;
    } hme_item_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic diag_step;
        logic hop_step;
        logic load_out;
    } hme_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  hop_empty;
        logic  last_site;
        logic  last_hop;
    } hme_status_t;

    function automatic logic signed [COEFF_WIDTH-1:0] to_coeff(
        input logic signed [FIELD_W-1:0] v
    );
        logic signed [31:0] wide;
        wide = 32'(v);
        return wide[COEFF_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hme_in_if.sv
// Input channel of the Hubbard matrix element block: valid, ready and the item fields.
// Depends on hme_pkg for field widths.
`default_nettype none

interface hme_in_if;
    import hme_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [MASK_W-1:0]         left_up;
    logic [MASK_W-1:0]         left_down;
    logic [MASK_W-1:0]         right_up;
    logic [MASK_W-1:0]         right_down;
    logic [INDEX_W-1:0]        entry_index;
    logic [SITE_SEL_W-1:0]     from_site;
    logic [SITE_SEL_W-1:0]     to_site;
    logic signed [FIELD_W-1:0] coeff_main;
    logic signed [FIELD_W-1:0] chem_up;
    logic signed [FIELD_W-1:0] chem_down;

    modport source (
        output valid, op, left_up, left_down, right_up, right_down, entry_index,
               from_site, to_site, coeff_main, chem_up, chem_down,
        input  ready
    );

    modport sink (
        input  valid, op, left_up, left_down, right_up, right_down, entry_index,
               from_site, to_site, coeff_main, chem_up, chem_down,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/hme_out_if.sv
// Result channel of the Hubbard matrix element block: valid, ready and the result fields.
// Depends on hme_pkg for field widths.
`default_nettype none

interface hme_out_if;
    import hme_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] element_value;
    logic                       write_done;

    modport source (
        output valid, element_value, write_done,
        input  ready
    );

    modport sink (
        input  valid, element_value, write_done,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/hme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

FILE: rtl/core/hme_ctrl.sv
// Controller state machine of the Hubbard matrix element block.
// Depends on hme_pkg for the command and status types.
`default_nettype none

module hme_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  hme_pkg::hme_status_t status,
    output hme_pkg::hme_cmd_t    cmd
);
    import hme_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_DIAG   = 3'd2;
    localparam logic [2:0] S_HOP    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       out_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign out_free     = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.capture   = item_valid && item_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.clear = 1'b1;
                if (status.mode == MODE_DIAG)
                begin
                    state_next = S_DIAG;
                end
                else if (status.mode == MODE_HOP && !status.hop_empty)
                begin
                    state_next = S_HOP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIAG:
            begin
                cmd.diag_step = 1'b1;
                if (status.last_site)
                begin
                    state_next = S_FINISH;
                end
            end
            S_HOP:
            begin
                cmd.hop_step = 1'b1;
                if (status.last_hop)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end
endmodule

`default_nettype wire

FILE: rtl/core/hme_datapath.sv
// Datapath of the Hubbard matrix element block: configuration, coefficient storage,
// hopping table RAM, accumulator and result register. Depends on hme_pkg and hme_ram.
`default_nettype none

module hme_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hme_pkg::hme_cmd_t                  cmd,
    input  hme_pkg::hme_item_t                 item_data,
    input  logic                               cfg_we,
    input  logic [hme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hme_pkg::CFG_DATA_W-1:0]     cfg_data,
    output hme_pkg::hme_status_t               status,
    output logic signed [hme_pkg::RESULT_W-1:0] element_value,
    output logic                               write_done
);
    import hme_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'h7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [SITE_CNT_W-1:0] site_count_reg;
    logic [HOP_CNT_W-1:0]  hop_count_reg;
    logic [SITE_LIM_W-1:0] n_eff;
    logic [HOP_LIM_W-1:0]  cnt_eff;

    logic signed [COEFF_WIDTH-1:0] site_int_reg [MAX_SITES];
    logic signed [COEFF_WIDTH-1:0] site_up_reg  [MAX_SITES];
    logic signed [COEFF_WIDTH-1:0] site_dn_reg  [MAX_SITES];

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [MASK_W-1:0] diag_u_reg;
    logic [MASK_W-1:0] diag_d_reg;
    logic [MASK_W-1:0] hop_l_reg;
    logic [MASK_W-1:0] hop_r_reg;
    logic [MASK_W-1:0] hop_l_next;
    logic [MASK_W-1:0] hop_r_next;

    logic [STEP_W-1:0]       counter_reg;
    logic [STEP_W-1:0]       counter_next;
    logic [31:0]             counter_ext;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic                    ram_we;
    logic [31:0]             widx_ext;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic [SITE_ADDR_W-1:0]  site_sel;
    logic                    bit_u;
    logic                    bit_d;
    logic signed [ACC_W-1:0] diag_term;

    logic [SITE_SEL_W-1:0]         hop_a;
    logic [SITE_SEL_W-1:0]         hop_b;
    logic [SITE_SEL_W-1:0]         hop_lo;
    logic [SITE_SEL_W-1:0]         hop_hi;
    logic signed [COEFF_WIDTH-1:0] hop_amp;
    logic [MASK_W-1:0]             between;
    logic [MASK_W-1:0]             move_mask;
    logic                          hop_take;
    logic signed [ACC_W-1:0]       amp_ext;
    logic signed [ACC_W-1:0]       hop_term;

    logic signed [RESULT_W-1:0] element_value_reg;
    logic                       write_done_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= SITE_CNT_W'(12);
            hop_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SITE_COUNT: site_count_reg <= cfg_data[SITE_CNT_W-1:0];
                REG_HOP_COUNT:  hop_count_reg  <= cfg_data[HOP_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (site_count_reg == '0)
        begin
            n_eff = SITE_LIM_W'(1);
        end
        else if (32'(site_count_reg) > MAX_SITES)
        begin
            n_eff = SITE_LIM_W'(MAX_SITES);
        end
        else
        begin
            n_eff = SITE_LIM_W'(site_count_reg);
        end

        if (32'(hop_count_reg) > MAX_HOPS)
        begin
            cnt_eff = HOP_LIM_W'(MAX_HOPS);
        end
        else
        begin
            cnt_eff = HOP_LIM_W'(hop_count_reg);
        end
    end

    // Per-site coefficients, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SITES; i++)
            begin
                site_int_reg[i] <= '0;
                site_up_reg[i]  <= '0;
                site_dn_reg[i]  <= '0;
            end
        end
        else if (cmd.capture && item_data.op == OP_SITE_WRITE
                 && 32'(item_data.entry_index) < MAX_SITES)
        begin
            site_int_reg[SITE_ADDR_W'(item_data.entry_index)] <= to_coeff(item_data.coeff_main);
            site_up_reg[SITE_ADDR_W'(item_data.entry_index)]  <= to_coeff(item_data.chem_up);
            site_dn_reg[SITE_ADDR_W'(item_data.entry_index)]  <= to_coeff(item_data.chem_down);
        end
    end

    // Hopping table.
    assign widx_ext  = 32'(item_data.entry_index);
    assign ram_we    = cmd.capture && item_data.op == OP_HOP_WRITE
                       && widx_ext < MAX_HOPS;
    assign ram_wdata = {item_data.from_site, item_data.to_site,
                        to_coeff(item_data.coeff_main)};

    hme_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_HOPS)
    ) u_hop_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_ext[HOP_ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (counter_next[HOP_ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Classification of an evaluation item.
    always_comb
    begin
        mode_next  = MODE_ZERO;
        hop_l_next = item_data.left_up;
        hop_r_next = item_data.right_up;
        if (item_data.op == OP_HOP_WRITE || item_data.op == OP_SITE_WRITE)
        begin
            mode_next = MODE_WRITE;
        end
        else if (item_data.op == OP_EVAL)
        begin
            if (item_data.left_up == item_data.right_up
                && item_data.left_down == item_data.right_down)
            begin
                mode_next = MODE_DIAG;
            end
            else if (item_data.left_up == item_data.right_up)
            begin
                mode_next  = MODE_HOP;
                hop_l_next = item_data.left_down;
                hop_r_next = item_data.right_down;
            end
            else if (item_data.left_down == item_data.right_down)
            begin
                mode_next = MODE_HOP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ZERO;
        end
        else if (cmd.capture)
        begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            diag_u_reg <= item_data.left_up;
            diag_d_reg <= item_data.left_down;
            hop_l_reg  <= hop_l_next;
            hop_r_reg  <= hop_r_next;
        end
    end

    // Diagonal term of the current site.
    assign counter_ext = 32'(counter_reg);
    assign site_sel    = counter_reg[SITE_ADDR_W-1:0];
    assign bit_u       = diag_u_reg[counter_ext[MASK_IDX_W-1:0]];
    assign bit_d       = diag_d_reg[counter_ext[MASK_IDX_W-1:0]];

    always_comb
    begin
        diag_term = '0;
        if (bit_u && bit_d)
        begin
            diag_term = ACC_W'(site_int_reg[site_sel]);
        end
        if (bit_u)
        begin
            diag_term = diag_term + ACC_W'(site_up_reg[site_sel]);
        end
        if (bit_d)
        begin
            diag_term = diag_term + ACC_W'(site_dn_reg[site_sel]);
        end
    end

    // Hopping term of the current table entry.
    assign hop_a   = ram_rdata[ENTRY_W-1 -: SITE_SEL_W];
    assign hop_b   = ram_rdata[ENTRY_W-SITE_SEL_W-1 -: SITE_SEL_W];
    assign hop_amp = signed'(ram_rdata[COEFF_WIDTH-1:0]);
    assign hop_lo  = (hop_a < hop_b) ? hop_a : hop_b;
    assign hop_hi  = (hop_a < hop_b) ? hop_b : hop_a;

    always_comb
    begin
        for (int j = 0; j < MASK_W; j++)
        begin
            between[j] = (j > int'(hop_lo)) && (j < int'(hop_hi));
        end
    end

    assign move_mask = (MASK_W'(1) << hop_a) ^ (MASK_W'(1) << hop_b);
    assign hop_take  = (32'(hop_a) < 32'(n_eff)) && (32'(hop_b) < 32'(n_eff))
                       && (hop_a != hop_b)
                       && (hop_r_reg[hop_a] ^ hop_r_reg[hop_b])
                       && (hop_l_reg == (hop_r_reg ^ move_mask));
    assign amp_ext   = ACC_W'(hop_amp);
    assign hop_term  = (^(hop_r_reg & between)) ? -amp_ext : amp_ext;

    // Step counter and accumulator.
    always_comb
    begin
        counter_next = counter_reg;
        acc_next     = acc_reg;
        if (cmd.clear)
        begin
            counter_next = '0;
            acc_next     = '0;
        end
        else if (cmd.diag_step)
        begin
            counter_next = counter_reg + STEP_W'(1);
            acc_next     = acc_reg + diag_term;
        end
        else if (cmd.hop_step)
        begin
            counter_next = counter_reg + STEP_W'(1);
            if (hop_take)
            begin
                acc_next = acc_reg + hop_term;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign status.mode      = mode_reg;
    assign status.hop_empty = (cnt_eff == '0);
    assign status.last_site = (counter_ext == 32'(n_eff) - 32'd1);
    assign status.last_hop  = (counter_ext == 32'(cnt_eff) - 32'd1);

    // Result register with saturation.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (acc_reg > SAT_HI)
            begin
                element_value_reg <= RESULT_W'(SAT_HI);
            end
            else if (acc_reg < SAT_LO)
            begin
                element_value_reg <= RESULT_W'(SAT_LO);
            end
            else
            begin
                element_value_reg <= RESULT_W'(acc_reg);
            end
            write_done_reg <= (mode_reg == MODE_WRITE);
        end
    end

    assign element_value = element_value_reg;
    assign write_done    = write_done_reg;
endmodule

`default_nettype wire

FILE: rtl/core/hubbard_matrix_element.sv
// Top level of the Hubbard matrix element block: controller, datapath and channel ports.
// Depends on hme_pkg, hme_in_if, hme_out_if, hme_ctrl and hme_datapath.
//
//   Channel   Direction  Handshake        Carries
//   item      in         valid / ready    op, four occupation masks, table write fields
//   result    out        valid / ready    element_value, write_done
//   cfg       in         cfg_we           site_count (index 0), hop_count (index 1)
//
// A table write, op 3, a zero element or a hop with no active entries passes through the
// setup and finish states into the result register, and the controller returns to idle and
// accepts the next transaction. A diagonal element also steps through the n active sites,
// one site per cycle, and a hopping element through each active entry (hop_count, at most 32).
// Reset sets site_count to 12, hop_count to 0 and clears the site coefficients; the hopping
// table holds no defined value until written. A result waits in the output register while the
// next transaction is accepted; the block holds its finished result when that register is full.
`default_nettype none

module hubbard_matrix_element (
    input  logic                           clk,
    input  logic                           rst_n,
    hme_in_if.sink                         item,
    hme_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [hme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hme_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hme_pkg::*;

    hme_item_t   item_data;
    hme_cmd_t    cmd;
    hme_status_t status;

    assign item_data.op          = item.op;
    assign item_data.left_up     = item.left_up;
    assign item_data.left_down   = item.left_down;
    assign item_data.right_up    = item.right_up;
    assign item_data.right_down  = item.right_down;
    assign item_data.entry_index = item.entry_index;
    assign item_data.from_site   = item.from_site;
    assign item_data.to_site     = item.to_site;
    assign item_data.coeff_main  = item.coeff_main;
    assign item_data.chem_up     = item.chem_up;
    assign item_data.chem_down   = item.chem_down;

    hme_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    hme_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_data     (item_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .element_value (result.element_value),
        .write_done    (result.write_done)
    );
endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for hubbard_matrix_element: directed and random transactions on the item channel.
// Each result is checked against an in-bench model of the Hubbard matrix element.
// Depends on hme_pkg, hme_in_if, hme_out_if and the RTL of the block.

module testbench;
    import hme_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES = 3 * MAX_HOPS;
    localparam int ITEMS_PER_SETTING = 118;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam longint ELEM_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ELEM_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic done;
    } element_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hme_in_if item_ch();
    hme_out_if result_ch();

    hubbard_matrix_element dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [SITE_SEL_W-1:0] hop_from_tab [MAX_HOPS];
    logic [SITE_SEL_W-1:0] hop_to_tab [MAX_HOPS];
    logic signed [COEFF_WIDTH-1:0] hop_amp_tab [MAX_HOPS];
    logic signed [COEFF_WIDTH-1:0] onsite_u_tab [MAX_SITES];
    logic signed [COEFF_WIDTH-1:0] pot_up_tab [MAX_SITES];
    logic signed [COEFF_WIDTH-1:0] pot_dn_tab [MAX_SITES];
    logic [SITE_CNT_W-1:0] sites_reg;
    logic [HOP_CNT_W-1:0] hops_reg;

    element_t pending_elements[$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cfg_step = 0;

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        element_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_elements.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: value %0d done %0b",
                             $signed(result_ch.element_value), result_ch.write_done);
            end
            else
            begin
                want = pending_elements.pop_front();
                if (result_ch.element_value !== want.value ||
                    result_ch.write_done !== want.done)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result mismatch: expected value %0d done %0b, got value %0d done %0b",
                                 $signed(want.value), want.done,
                                 $signed(result_ch.element_value), result_ch.write_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int active_sites();
        int n;
        n = int'(sites_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_SITES)
            n = MAX_SITES;
        return n;
    endfunction

    function automatic int active_hops();
        int n;
        n = int'(hops_reg);
        if (n > MAX_HOPS)
            n = MAX_HOPS;
        return n;
    endfunction

    function automatic longint diagonal_energy(logic [MASK_W-1:0] up, logic [MASK_W-1:0] dn);
        longint acc;
        int n;
        acc = 0;
        n = active_sites();
        for (int i = 0; i < n; i++)
        begin
            if (up[i] && dn[i])
                acc += longint'(onsite_u_tab[i]);
            if (up[i])
                acc += longint'(pot_up_tab[i]);
            if (dn[i])
                acc += longint'(pot_dn_tab[i]);
        end
        return acc;
    endfunction

    // Sign of a hop is the parity of the right mask strictly between the two sites.
    function automatic longint hopping_sum(logic [MASK_W-1:0] l, logic [MASK_W-1:0] r);
        longint acc;
        longint amp;
        int n, lim, a, b, lo, hi;
        logic [MASK_W-1:0] between, moved;
        acc = 0;
        n = active_sites();
        lim = active_hops();
        for (int i = 0; i < lim; i++)
        begin
            a = int'(hop_from_tab[i]);
            b = int'(hop_to_tab[i]);
            if (a >= n || b >= n || a == b)
                continue;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            between = MASK_W'(((32'd1 << hi) - 1) & ~((32'd1 << (lo + 1)) - 1));
            amp = longint'(hop_amp_tab[i]);
            if (^(r & between))
                amp = -amp;
            moved = r ^ MASK_W'(32'd1 << a) ^ MASK_W'(32'd1 << b);
            if (r[a] && !r[b] && l == moved)
                acc += amp;
            if (r[b] && !r[a] && l == moved)
                acc += amp;
        end
        return acc;
    endfunction

    function automatic element_t compute_element(hme_item_t it);
        element_t res;
        longint v;
        res = '0;
        v = 0;
        case (it.op)
            OP_EVAL:
            begin
                if (it.left_up == it.right_up && it.left_down == it.right_down)
                    v = diagonal_energy(it.left_up, it.left_down);
                else if (it.left_up == it.right_up)
                    v = hopping_sum(it.left_down, it.right_down);
                else if (it.left_down == it.right_down)
                    v = hopping_sum(it.left_up, it.right_up);
                if (v > ELEM_MAX)
                    v = ELEM_MAX;
                if (v < ELEM_MIN)
                    v = ELEM_MIN;
                res.value = v[RESULT_W-1:0];
            end
            OP_HOP_WRITE:
            begin
                res.done = 1'b1;
                if (it.entry_index < MAX_HOPS)
                begin
                    hop_from_tab[it.entry_index] = it.from_site;
                    hop_to_tab[it.entry_index] = it.to_site;
                    hop_amp_tab[it.entry_index] = it.coeff_main[COEFF_WIDTH-1:0];
                end
            end
            OP_SITE_WRITE:
            begin
                res.done = 1'b1;
                if (it.entry_index < MAX_SITES)
                begin
                    onsite_u_tab[it.entry_index] = it.coeff_main[COEFF_WIDTH-1:0];
                    pot_up_tab[it.entry_index] = it.chem_up[COEFF_WIDTH-1:0];
                    pot_dn_tab[it.entry_index] = it.chem_down[COEFF_WIDTH-1:0];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic hme_item_t eval_item(logic [MASK_W-1:0] lu, logic [MASK_W-1:0] ld,
                                            logic [MASK_W-1:0] ru, logic [MASK_W-1:0] rd);
        hme_item_t it;
        it = '0;
        it.op = OP_EVAL;
        it.left_up = lu;
        it.left_down = ld;
        it.right_up = ru;
        it.right_down = rd;
        return it;
    endfunction

    function automatic hme_item_t hop_item(logic [INDEX_W-1:0] idx, logic [SITE_SEL_W-1:0] a,
                                           logic [SITE_SEL_W-1:0] b,
                                           logic signed [FIELD_W-1:0] amp);
        hme_item_t it;
        it = '0;
        it.op = OP_HOP_WRITE;
        it.entry_index = idx;
        it.from_site = a;
        it.to_site = b;
        it.coeff_main = amp;
        return it;
    endfunction

    function automatic hme_item_t site_item(logic [INDEX_W-1:0] idx,
                                            logic signed [FIELD_W-1:0] u,
                                            logic signed [FIELD_W-1:0] up,
                                            logic signed [FIELD_W-1:0] dn);
        hme_item_t it;
        it = '0;
        it.op = OP_SITE_WRITE;
        it.entry_index = idx;
        it.coeff_main = u;
        it.chem_up = up;
        it.chem_down = dn;
        return it;
    endfunction

    function automatic logic signed [FIELD_W-1:0] random_coeff();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return FIELD_W'($urandom_range(0, 8191)) - 24'd4096;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_mask(int n);
        logic [MASK_W-1:0] m;
        m = MASK_W'($urandom);
        if ($urandom_range(0, 4) != 0)
            m &= MASK_W'((32'd1 << n) - 1);
        return m;
    endfunction

    // Most evaluations are diagonal or a single legal hop drawn from the current table.
    function automatic hme_item_t random_item();
        hme_item_t it;
        int n, lim, pick, k;
        logic [MASK_W-1:0] r, l, other;
        logic [SITE_SEL_W-1:0] a, b;
        n = active_sites();
        lim = active_hops();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                a = SITE_SEL_W'($urandom_range(0, n - 1));
                b = SITE_SEL_W'($urandom_range(0, n - 1));
            end
            else
            begin
                a = SITE_SEL_W'($urandom_range(0, 15));
                b = SITE_SEL_W'($urandom_range(0, 15));
            end
            it = hop_item(INDEX_W'($urandom_range(0, MAX_HOPS - 1)), a, b, random_coeff());
        end
        else if (pick < 20)
        begin
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                            : $urandom_range(0, MAX_SITES - 1);
            it = site_item(INDEX_W'(k), random_coeff(), random_coeff(), random_coeff());
        end
        else if (pick < 23)
        begin
            it = site_item(INDEX_W'($urandom_range(0, 31)), random_coeff(), random_coeff(),
                           random_coeff());
            it.op = OP_NONE;
            it.left_up = MASK_W'($urandom);
            it.right_down = MASK_W'($urandom);
            it.from_site = SITE_SEL_W'($urandom);
            it.to_site = SITE_SEL_W'($urandom);
        end
        else
        begin
            r = random_mask(n);
            other = random_mask(n);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                l = r;
            else if (pick < 8 && lim > 0)
            begin
                k = $urandom_range(0, lim - 1);
                a = hop_from_tab[k];
                b = hop_to_tab[k];
                if ($urandom_range(0, 1))
                begin
                    r[a] = 1'b1;
                    r[b] = 1'b0;
                end
                else
                begin
                    r[b] = 1'b1;
                    r[a] = 1'b0;
                end
                l = r ^ MASK_W'(32'd1 << a) ^ MASK_W'(32'd1 << b);
            end
            else
                l = random_mask(n);
            if (pick == 9)
                it = eval_item(l, random_mask(n), r, other);
            else if ($urandom_range(0, 1))
                it = eval_item(l, other, r, other);
            else
                it = eval_item(other, l, other, r);
        end
        return it;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, with valid still high so back-to-back transactions need no gap.
    task automatic send_item(input hme_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.op = it.op;
        item_ch.left_up = it.left_up;
        item_ch.left_down = it.left_down;
        item_ch.right_up = it.right_up;
        item_ch.right_down = it.right_down;
        item_ch.entry_index = it.entry_index;
        item_ch.from_site = it.from_site;
        item_ch.to_site = it.to_site;
        item_ch.coeff_main = it.coeff_main;
        item_ch.chem_up = it.chem_up;
        item_ch.chem_down = it.chem_down;
        item_ch.valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        pending_elements.push_back(compute_element(it));
        @(negedge clk);
    endtask

    task automatic drain();
        item_ch.valid = 1'b0;
        while (pending_elements.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (index == REG_SITE_COUNT)
            sites_reg = value[SITE_CNT_W-1:0];
        else
            hops_reg = value[HOP_CNT_W-1:0];
    endtask

    task automatic test_directed();
        hme_item_t it;
        send_item(eval_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(site_item(5'd0, 24'h7FFFFF, 24'h800000, 24'h000001));
        send_item(site_item(5'd11, 24'hFFFFFF, 24'h000800, 24'h7FFFFF));
        send_item(site_item(5'd15, 24'h400000, 24'h400000, 24'h400000));
        send_item(site_item(5'd31, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        it = site_item(5'd3, 24'h123456, 24'h654321, 24'h0ABCDE);
        it.op = OP_NONE;
        send_item(it);
        send_item(eval_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(eval_item(16'h0001, 16'h0800, 16'h0001, 16'h0800));
        send_item(eval_item(16'h0008, 16'h0008, 16'h0008, 16'h0008));
        send_item(hop_item(5'd0, 4'd0, 4'd3, 24'h7FFFFF));
        send_item(hop_item(5'd1, 4'd5, 4'd2, 24'h800000));
        send_item(hop_item(5'd2, 4'd4, 4'd4, 24'h001000));
        send_item(hop_item(5'd3, 4'd13, 4'd1, 24'h002000));
        write_config(REG_HOP_COUNT, 6'd4);
        send_item(eval_item(16'h0008, 16'h00F0, 16'h0001, 16'h00F0));
        send_item(eval_item(16'h000A, 16'h0000, 16'h0003, 16'h0000));
        send_item(eval_item(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0008));
        send_item(eval_item(16'h0000, 16'h0028, 16'h0000, 16'h000C));
        send_item(eval_item(16'h8008, 16'h0000, 16'h8001, 16'h0000));
        send_item(eval_item(16'h0002, 16'h0000, 16'h2000, 16'h0000));
        send_item(eval_item(16'hFFFF, 16'h0001, 16'h0000, 16'h0002));
        send_item(eval_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        write_config(REG_SITE_COUNT, 6'd0);
        send_item(eval_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(eval_item(16'h0008, 16'h0000, 16'h0001, 16'h0000));
    endtask

    // Every hopping entry gets a value before any hop count can reach it.
    task automatic test_table_fill();
        for (int i = 0; i < MAX_HOPS; i++)
            send_item(hop_item(INDEX_W'(i), SITE_SEL_W'($urandom_range(0, 15)),
                               SITE_SEL_W'($urandom_range(0, 15)), random_coeff()));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [CFG_DATA_W-1:0] site_settings [8] = '{6'd16, 6'd1, 6'd0, 6'd31,
                                                     6'd5, 6'd12, 6'd8, 6'd2};
        logic [CFG_DATA_W-1:0] hop_settings [6] = '{6'd32, 6'd0, 6'd63, 6'd9, 6'd1, 6'd20};
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++)
        begin
            write_config(REG_SITE_COUNT, site_settings[cfg_step % 8]);
            write_config(REG_HOP_COUNT, hop_settings[cfg_step % 6]);
            cfg_step++;
            repeat (ITEMS_PER_SETTING)
                send_item(random_item());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        result_ch.ready = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_EVAL;
        item_ch.left_up = '0;
        item_ch.left_down = '0;
        item_ch.right_up = '0;
        item_ch.right_down = '0;
        item_ch.entry_index = '0;
        item_ch.from_site = '0;
        item_ch.to_site = '0;
        item_ch.coeff_main = '0;
        item_ch.chem_up = '0;
        item_ch.chem_down = '0;
        sites_reg = SITE_CNT_W'(12);
        hops_reg = '0;
        for (int i = 0; i < MAX_HOPS; i++)
        begin
            hop_from_tab[i] = '0;
            hop_to_tab[i] = '0;
            hop_amp_tab[i] = '0;
        end
        for (int i = 0; i < MAX_SITES; i++)
        begin
            onsite_u_tab[i] = '0;
            pot_up_tab[i] = '0;
            pot_dn_tab[i] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_fill();
        test_random_traffic(0, 0);
        test_random_traffic(86, 0);
        test_random_traffic(0, 86);
        test_random_traffic(9, 9);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_elements.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/hme_pkg.sv
rtl/core/hme_in_if.sv
rtl/core/hme_out_if.sv
rtl/core/hme_ram.sv
rtl/core/hme_ctrl.sv
rtl/core/hme_datapath.sv
rtl/core/hubbard_matrix_element.sv
test/testbench.sv
